FILE: rtl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg: shared definitions for the datagram CRC checker
// Header layout, acknowledgement constants, CRC-32 byte update and the
// acknowledgement record passed to the output queue.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam int unsigned DCC_MAX_DATAGRAM = 65535;

	localparam int unsigned HDR_BYTES    = 14;
	localparam int unsigned PORT_HI_POS  = 4;
	localparam int unsigned PORT_LO_POS  = 5;
	localparam int unsigned CRC_FIRST_POS = 10;

	localparam logic [7:0]  ACK_HEAD   = 8'hAA;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
	localparam int unsigned ACK_BYTES  = 5;
	localparam logic [2:0]  ACK_LAST_IDX = 3'(ACK_BYTES - 1);

	typedef struct packed {
		logic [31:0] count;
		logic        crc_ok;
		logic        short_datagram;
		logic [15:0] sender_port;
		logic [31:0] good_count;
		logic [31:0] error_count;
	} ack_rec_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/dcc_if.sv
// ----------------------------------------------------------------------------
// dcc_if: item channels of the datagram CRC checker
// Byte input channel and acknowledgement output channel, valid/ready.
// ----------------------------------------------------------------------------
interface dcc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_datagram;

	modport source(output valid, data_byte, end_of_datagram, input ready);
	modport sink(input valid, data_byte, end_of_datagram, output ready);
endinterface

interface dcc_ack_if;
	logic        valid;
	logic        ready;
	logic [7:0]  ack_byte;
	logic        ack_last;
	logic        crc_ok;
	logic        short_datagram;
	logic [15:0] sender_port;
	logic [31:0] good_count;
	logic [31:0] error_count;

	modport source(output valid, ack_byte, ack_last, crc_ok, short_datagram, sender_port,
		good_count, error_count, input ready);
	modport sink(input valid, ack_byte, ack_last, crc_ok, short_datagram, sender_port,
		good_count, error_count, output ready);
endinterface

FILE: rtl/datagram_crc_checker_ack.sv
// ----------------------------------------------------------------------------
// datagram_crc_checker_ack: framed datagram receiver with CRC-32 check
// Parses the 14-byte header, runs CRC-32 over the payload, counts good and
// bad datagrams and answers each datagram with five acknowledgement items.
//
//   channel  dir  items                     handshake
//   rx       in   data_byte, end_of_datagram  valid/ready
//   ack      out  ack_byte .. error_count     valid/ready
//
// Header and CRC update at each taken byte, the counters at a final byte.
// A final byte queues a record: five items, one per cycle unless ack stalls.
// Up to two records wait; rx.ready drops while both slots are taken.
// Reset clears counters, queue and datagram state; no clearing pass.
// ----------------------------------------------------------------------------
module datagram_crc_checker_ack
	import dcc_pkg::*;
#(
	parameter int unsigned MAX_DATAGRAM = DCC_MAX_DATAGRAM
)(
	input  logic      clk,
	input  logic      arst_n,
	dcc_in_if.sink    rx,
	dcc_ack_if.source ack
);

	localparam int unsigned PW = $clog2(MAX_DATAGRAM + 1);

	logic [PW-1:0] pos_q;
	logic [31:0]   hdr_crc_q;
	logic [31:0]   crc_q;
	logic [15:0]   port_q;
	logic [31:0]   good_q;
	logic [31:0]   error_q;

	logic          rx_fire;
	logic          queue_full;
	logic [PW-1:0] pos_d;
	logic [31:0]   hdr_crc_d;
	logic [31:0]   crc_d;
	logic [15:0]   port_d;
	logic          is_short;
	logic          ok;
	logic [31:0]   good_d;
	logic [31:0]   error_d;
	ack_rec_t      rec;

	assign rx.ready = !queue_full;
	assign rx_fire  = rx.valid && rx.ready;

	always_comb begin
		pos_d     = pos_q;
		hdr_crc_d = hdr_crc_q;
		crc_d     = crc_q;
		port_d    = port_q;
		if (pos_q < PW'(MAX_DATAGRAM)) begin
			pos_d = pos_q + PW'(1);
			if (pos_q < PW'(HDR_BYTES)) begin
				if (pos_q == PW'(PORT_HI_POS) || pos_q == PW'(PORT_LO_POS)) begin
					port_d = {port_q[7:0], rx.data_byte};
				end else if (pos_q >= PW'(CRC_FIRST_POS)) begin
					hdr_crc_d = {hdr_crc_q[23:0], rx.data_byte};
				end
			end else begin
				crc_d = crc_byte(crc_q, rx.data_byte);
			end
		end
		is_short = pos_d < PW'(HDR_BYTES);
		ok       = !is_short && ((crc_d ^ CRC_INIT) == hdr_crc_d);
		good_d   = good_q;
		error_d  = error_q;
		if (ok) begin
			if (good_q != COUNT_MAX) begin
				good_d = good_q + 32'd1;
			end
		end else if (error_q != COUNT_MAX) begin
			error_d = error_q + 32'd1;
		end
		rec.count          = 32'(pos_d);
		rec.crc_ok         = ok;
		rec.short_datagram = is_short;
		rec.sender_port    = is_short ? 16'h0 : port_d;
		rec.good_count     = good_d;
		rec.error_count    = error_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hdr_crc_q <= '0;
			crc_q     <= CRC_INIT;
			port_q    <= '0;
			good_q    <= '0;
			error_q   <= '0;
		end else if (rx_fire) begin
			if (rx.end_of_datagram) begin
				pos_q     <= '0;
				hdr_crc_q <= '0;
				crc_q     <= CRC_INIT;
				port_q    <= '0;
				good_q    <= good_d;
				error_q   <= error_d;
			end else begin
				pos_q     <= pos_d;
				hdr_crc_q <= hdr_crc_d;
				crc_q     <= crc_d;
				port_q    <= port_d;
			end
		end
	end

	dcc_ack_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rx_fire && rx.end_of_datagram),
		.push_rec (rec),
		.full     (queue_full),
		.ack      (ack)
	);

	a_ack_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && rx.end_of_datagram |=> ack.valid)
		else $error("no acknowledgement after final byte");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_DATAGRAM)) else $error("byte position beyond maximum");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && rx.end_of_datagram |=> pos_q == '0 && crc_q == CRC_INIT)
		else $error("datagram state not restarted");

endmodule

FILE: rtl/dcc_ack_queue.sv
// ----------------------------------------------------------------------------
// dcc_ack_queue: acknowledgement record queue and serialiser
// Holds up to two finished records and sends each as five items.
// ----------------------------------------------------------------------------
module dcc_ack_queue
	import dcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ack_rec_t  push_rec,
	output logic      full,
	dcc_ack_if.source ack
);

	ack_rec_t   head_q;
	ack_rec_t   spare_q;
	logic       head_v_q;
	logic       spare_v_q;
	logic [2:0] idx_q;
	logic       pop;
	logic       pop_done;
	logic [39:0] ack_word;

	assign pop      = ack.valid && ack.ready;
	assign pop_done = pop && (idx_q == ACK_LAST_IDX);
	assign full     = spare_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q  <= 1'b0;
			spare_v_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (pop_done) begin
				idx_q <= '0;
				if (spare_v_q) begin
					head_v_q  <= 1'b1;
					spare_v_q <= push;
				end else begin
					head_v_q <= push;
				end
			end else begin
				if (pop) begin
					idx_q <= idx_q + 3'd1;
				end
				if (push && !head_v_q) begin
					head_v_q <= 1'b1;
				end else if (push) begin
					spare_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_done) begin
			if (spare_v_q) begin
				head_q <= spare_q;
				if (push) begin
					spare_q <= push_rec;
				end
			end else if (push) begin
				head_q <= push_rec;
			end
		end else if (push && !head_v_q) begin
			head_q <= push_rec;
		end else if (push) begin
			spare_q <= push_rec;
		end
	end

	assign ack_word           = {ACK_HEAD, head_q.count};
	assign ack.valid          = head_v_q;
	assign ack.ack_byte       = ack_word[8 * (3'(ACK_BYTES - 1) - idx_q) +: 8];
	assign ack.ack_last       = (idx_q == ACK_LAST_IDX);
	assign ack.crc_ok         = head_q.crc_ok;
	assign ack.short_datagram = head_q.short_datagram;
	assign ack.sender_port    = head_q.sender_port;
	assign ack.good_count     = head_q.good_count;
	assign ack.error_count    = head_q.error_count;

	a_spare_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		spare_v_q |-> head_v_q) else $error("spare record without head record");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= ACK_LAST_IDX) else $error("acknowledgement index out of range");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_done && !spare_v_q && !push |=> !head_v_q && idx_q == '0)
		else $error("queue not empty after last record sent");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for datagram_crc_checker_ack
// Feeds framed datagrams byte by byte (good, corrupted, short and header-only),
// predicts the five acknowledgement items of each one and compares every
// accepted item field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench
	import dcc_pkg::*;
();

	localparam logic [31:0] CRC32_POLY  = 32'hEDB8_8320;
	localparam int unsigned FRAME_MAX   = DCC_MAX_DATAGRAM;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned RX_BYTES    = 250;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned HOLD_AFTER  = 60;
	localparam int unsigned SETTLE      = 20;

	typedef logic [7:0] octet_q_t [$];

	typedef enum {INTACT, BAD_CRC_FIELD, BAD_PAYLOAD} damage_t;

	typedef struct {
		logic [7:0] data;
		logic       eod;
		bit         drain_first;
	} rx_item_t;

	typedef struct {
		logic [7:0]  ack_byte;
		logic        ack_last;
		logic        crc_ok;
		logic        short_dg;
		logic [15:0] port;
		logic [31:0] good;
		logic [31:0] bad;
	} ack_item_t;

	logic clk;
	logic arst_n;

	dcc_in_if  rx_ch();
	dcc_ack_if ack_ch();

	datagram_crc_checker_ack DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.ack(ack_ch)
	);

	rx_item_t    byte_stream[$];
	ack_item_t   pending_acks[$];

	int unsigned frame_len = 0;
	logic [31:0] hdr_crc   = 32'h0;
	logic [31:0] run_crc   = 32'hFFFF_FFFF;
	logic [15:0] hdr_port  = 16'h0;
	logic [31:0] good_total = 32'h0;
	logic [31:0] bad_total  = 32'h0;

	int unsigned cycle_count  = 0;
	int unsigned bytes_taken  = 0;
	int unsigned acks_checked = 0;
	int unsigned mismatches   = 0;
	int unsigned hold_left    = 0;
	bit          hold_done    = 0;
	logic        rx_taken     = 1'b0;
	logic        calm;

	assign calm = (cycle_count % 5000) < 1000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] crc32_step(input logic [31:0] reg_in, input logic [7:0] octet);
		logic [31:0] r;
		r = reg_in ^ {24'd0, octet};
		repeat (8) r = (r >> 1) ^ (CRC32_POLY & {32{r[0]}});
		return r;
	endfunction

	function automatic logic [31:0] payload_crc(input octet_q_t data);
		logic [31:0] r;
		r = 32'hFFFF_FFFF;
		foreach (data[i]) r = crc32_step(r, data[i]);
		return ~r;
	endfunction

	task automatic take_byte(input logic [7:0] b, input logic eod);
		ack_item_t   rec;
		logic [31:0] count;
		if (frame_len < FRAME_MAX) begin
			if (frame_len < HDR_BYTES) begin
				if (frame_len == PORT_HI_POS || frame_len == PORT_LO_POS)
					hdr_port = {hdr_port[7:0], b};
				else if (frame_len >= CRC_FIRST_POS)
					hdr_crc = {hdr_crc[23:0], b};
			end else begin
				run_crc = crc32_step(run_crc, b);
			end
			frame_len++;
		end
		if (!eod) return;
		count        = 32'(frame_len);
		rec.short_dg = frame_len < HDR_BYTES;
		rec.crc_ok   = !rec.short_dg && (~run_crc == hdr_crc);
		if (rec.crc_ok) begin
			if (good_total != COUNT_MAX) good_total++;
		end else begin
			if (bad_total != COUNT_MAX) bad_total++;
		end
		rec.port = rec.short_dg ? 16'h0 : hdr_port;
		rec.good = good_total;
		rec.bad  = bad_total;
		for (int k = 0; k < 5; k++) begin
			rec.ack_byte = (k == 0) ? ACK_HEAD : 8'(count >> (8 * (4 - k)));
			rec.ack_last = (k == 4);
			pending_acks.insert(pending_acks.size(), rec);
		end
		frame_len = 0;
		hdr_crc   = 32'h0;
		run_crc   = 32'hFFFF_FFFF;
		hdr_port  = 16'h0;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: ack %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		ack_item_t want;
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d ack items outstanding",
				cycle_count, pending_acks.size());
			$display("datagram_crc_checker_ack: mismatch");
			$finish;
		end
		rx_taken <= rx_ch.valid && rx_ch.ready;
		if (arst_n && rx_ch.valid && rx_ch.ready) begin
			bytes_taken++;
			take_byte(rx_ch.data_byte, rx_ch.end_of_datagram);
		end
		if (arst_n && ack_ch.valid && ack_ch.ready) begin
			acks_checked++;
			if (pending_acks.size() == 0) begin
				$display("%0t: unexpected ack item, expected none got %0h",
					$time, ack_ch.ack_byte);
				mismatches++;
			end else begin
				want = pending_acks.pop_front();
				compare_field("ack_byte", 32'(want.ack_byte), 32'(ack_ch.ack_byte));
				compare_field("ack_last", 32'(want.ack_last), 32'(ack_ch.ack_last));
				compare_field("crc_ok", 32'(want.crc_ok), 32'(ack_ch.crc_ok));
				compare_field("short_datagram", 32'(want.short_dg),
					32'(ack_ch.short_datagram));
				compare_field("sender_port", 32'(want.port), 32'(ack_ch.sender_port));
				compare_field("good_count", want.good, ack_ch.good_count);
				compare_field("error_count", want.bad, ack_ch.error_count);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!rx_ch.valid || rx_taken)) begin
			if (byte_stream.size() == 0 || (!calm && $urandom_range(99) < 15) ||
					(byte_stream[0].drain_first && pending_acks.size() != 0)) begin
				rx_ch.valid <= 1'b0;
			end else begin
				rx_ch.valid           <= 1'b1;
				rx_ch.data_byte       <= byte_stream[0].data;
				rx_ch.end_of_datagram <= byte_stream[0].eod;
				void'(byte_stream.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				ack_ch.ready <= 1'b0;
				hold_left    <= hold_left - 1;
			end else if (!hold_done && acks_checked >= HOLD_AFTER) begin
				ack_ch.ready <= 1'b0;
				hold_left    <= HOLD_CYCLES;
				hold_done    <= 1'b1;
			end else begin
				ack_ch.ready <= calm || $urandom_range(99) >= 15;
			end
		end
	end

	task automatic queue_datagram(input octet_q_t dg, input bit drain_first);
		rx_item_t it;
		foreach (dg[i]) begin
			it.data        = dg[i];
			it.eod         = (i == dg.size() - 1);
			it.drain_first = drain_first && (i == 0);
			byte_stream.insert(byte_stream.size(), it);
		end
	endtask

	task automatic build_framed(input logic [15:0] port, input int unsigned payload_len,
			input damage_t damage, input int fill, output octet_q_t dg);
		octet_q_t    payload;
		logic [31:0] crc;
		logic [31:0] len_field;
		int unsigned spot;
		dg = {};
		payload = {};
		repeat (payload_len)
			payload.insert(payload.size(), fill < 0 ? 8'($urandom) : 8'(fill));
		crc = payload_crc(payload);
		if (damage == BAD_CRC_FIELD)
			crc ^= 32'h1 << $urandom_range(31);
		if (damage == BAD_PAYLOAD && payload_len != 0) begin
			spot = $urandom_range(payload_len - 1);
			payload[spot] ^= 8'h1 << $urandom_range(7);
		end
		len_field = $urandom_range(1) ? 32'(payload_len + HDR_BYTES) : $urandom;
		repeat (4) dg.insert(dg.size(), 8'($urandom));
		dg.insert(dg.size(), port[15:8]);
		dg.insert(dg.size(), port[7:0]);
		for (int k = 3; k >= 0; k--) dg.insert(dg.size(), len_field[8*k +: 8]);
		for (int k = 3; k >= 0; k--) dg.insert(dg.size(), crc[8*k +: 8]);
		foreach (payload[i]) dg.insert(dg.size(), payload[i]);
	endtask

	initial begin
		octet_q_t    dg;
		int unsigned random_bytes;
		int unsigned roll;
		int unsigned plen;
		damage_t     damage;
		bit          first;

		clk                   = 1'b0;
		arst_n                = 1'b0;
		rx_ch.valid           = 1'b0;
		rx_ch.data_byte       = 8'h00;
		rx_ch.end_of_datagram = 1'b0;
		ack_ch.ready          = 1'b0;

		dg = {8'h5A};
		queue_datagram(dg, 1'b0);
		dg = {};
		repeat (HDR_BYTES - 1) dg.insert(dg.size(), 8'hFF);
		queue_datagram(dg, 1'b0);
		build_framed(16'hBEEF, 0, INTACT, -1, dg);
		queue_datagram(dg, 1'b0);
		build_framed(16'h0101, 0, BAD_CRC_FIELD, -1, dg);
		queue_datagram(dg, 1'b0);
		build_framed(16'h0000, 8, INTACT, 0, dg);
		queue_datagram(dg, 1'b0);
		build_framed(16'hFFFF, 8, INTACT, 255, dg);
		queue_datagram(dg, 1'b0);
		build_framed(16'h8001, 12, BAD_PAYLOAD, -1, dg);
		queue_datagram(dg, 1'b0);
		build_framed(16'h7FFE, 5, BAD_CRC_FIELD, -1, dg);
		queue_datagram(dg, 1'b0);
		build_framed(16'h4321, 3, INTACT, -1, dg);
		queue_datagram(dg, 1'b1);

		random_bytes = 0;
		first = 1'b1;
		while (random_bytes < RX_BYTES) begin
			roll = $urandom_range(99);
			if (roll < 15) begin
				dg = {};
				repeat ($urandom_range(1, HDR_BYTES - 1)) dg.insert(dg.size(), 8'($urandom));
			end else begin
				damage = (roll < 23) ? BAD_CRC_FIELD : (roll < 30) ? BAD_PAYLOAD : INTACT;
				plen = ($urandom_range(99) < 80) ? $urandom_range(16) : $urandom_range(17, 60);
				build_framed(16'($urandom), plen, damage, -1, dg);
			end
			queue_datagram(dg, first || $urandom_range(99) < 6);
			random_bytes += dg.size();
			first = 1'b0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (byte_stream.size() == 0 && rx_ch.valid === 1'b0);
		wait (pending_acks.size() == 0);
		repeat (SETTLE) @(posedge clk);

		$display("%0d datagrams received (%0d good, %0d bad or short) over %0d bytes",
			acks_checked / 5, good_total, bad_total, bytes_taken);
		$display("%0d ack items checked, including header-only datagrams and a long ack stall",
			acks_checked);
		if (mismatches == 0) begin
			$display("datagram_crc_checker_ack: match");
		end else begin
			$display("datagram_crc_checker_ack: mismatch");
		end
		$finish;
	end

endmodule
